/* rtl/nfb_pkg.sv */
// ----------------------------------------------------------------------------
// nfb_pkg
// Shared types, request codes and nibble helpers for the framebuffer blitter.
// ----------------------------------------------------------------------------
package nfb_pkg;

  localparam int NFB_ROWS       = 64;
  localparam int NFB_GROUPS     = 64;
  localparam int NFB_CLIP_WIDTH = 128;

  localparam int WORD_W = 16;

  localparam logic [2:0] REQ_DRAW  = 3'd0;
  localparam logic [2:0] REQ_READ  = 3'd1;
  localparam logic [2:0] REQ_BEGIN = 3'd2;
  localparam logic [2:0] REQ_BYTE  = 3'd3;
  localparam logic [2:0] REQ_FETCH = 3'd4;

  localparam logic [WORD_W-1:0] NIBBLE_MASK = 16'h000f;
  localparam logic [WORD_W-1:0] HIGH_MASK   = 16'hff00;
  localparam logic [WORD_W-1:0] LOW_MASK    = 16'h00ff;
  localparam logic [3:0]        BPC_MAX     = 4'd15;
  localparam logic [3:0]        BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    logic accept;
    logic clear_step;
    logic mem_update;
    logic pic_setup;
    logic blit_step;
    logic pic_advance;
    logic respond;
  } nfb_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic blit_done;
  } nfb_status_t;

  // leftmost pixel in the top nibble
  function automatic logic [3:0] nibble_get(logic [WORD_W-1:0] word, logic [1:0] sel);
    logic [WORD_W-1:0] shifted;
    shifted = (word >> {~sel, 2'b00}) & NIBBLE_MASK;
    return shifted[3:0];
  endfunction

  function automatic logic [WORD_W-1:0] nibble_set(logic [WORD_W-1:0] word,
                                                   logic [1:0] sel, logic on);
    logic [WORD_W-1:0] mask;
    mask = NIBBLE_MASK << {~sel, 2'b00};
    return on ? (word | mask) : (word & ~mask);
  endfunction

endpackage

/* rtl/nfb_ram.sv */
// ----------------------------------------------------------------------------
// nfb_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module nfb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/nfb_ctrl.sv */
// ----------------------------------------------------------------------------
// nfb_ctrl
// Sequencer: clearing pass, pixel access, picture setup and byte blit.
// ----------------------------------------------------------------------------
module nfb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [2:0]          req_type,
  input  nfb_pkg::nfb_status_t status,
  output nfb_pkg::nfb_cmd_t    cmd,
  output logic                busy
);

  import nfb_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_UPDATE,
    S_SETUP,
    S_BLIT,
    S_ADVANCE
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          case (req_type)
            REQ_BEGIN: state_next = S_SETUP;
            REQ_BYTE:  state_next = S_BLIT;
            default:   state_next = S_LOOKUP;
          endcase
        end
      end
      S_LOOKUP:  state_next = S_UPDATE;
      S_UPDATE:  state_next = S_IDLE;
      S_SETUP:   state_next = S_IDLE;
      S_BLIT: begin
        if (status.blit_done) begin
          state_next = S_ADVANCE;
        end
      end
      S_ADVANCE: state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd             = '0;
    cmd.accept      = (state == S_IDLE) && start;
    cmd.clear_step  = (state == S_CLEAR);
    cmd.mem_update  = (state == S_UPDATE);
    cmd.pic_setup   = (state == S_SETUP);
    cmd.blit_step   = (state == S_BLIT);
    cmd.pic_advance = (state == S_ADVANCE);
    cmd.respond     = (state == S_UPDATE) || (state == S_SETUP) || (state == S_ADVANCE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      busy  <= 1'b1;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

/* rtl/nfb_datapath.sv */
// ----------------------------------------------------------------------------
// nfb_datapath
// Frame store, transaction latch, picture cursor and result registers.
// ----------------------------------------------------------------------------
module nfb_datapath #(
  parameter int ROWS       = nfb_pkg::NFB_ROWS,
  parameter int GROUPS     = nfb_pkg::NFB_GROUPS,
  parameter int CLIP_WIDTH = nfb_pkg::NFB_CLIP_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  nfb_pkg::nfb_cmd_t     cmd,
  output nfb_pkg::nfb_status_t  status,
  input  logic [2:0]           req_type,
  input  logic [7:0]           pos_x,
  input  logic [5:0]           pos_y,
  input  logic                 pixel_on,
  input  logic [7:0]           pic_width,
  input  logic [6:0]           pic_height,
  input  logic [7:0]           pic_data,
  output logic                 done,
  output logic [3:0]           read_value,
  output logic [7:0]           word_high,
  output logic [7:0]           word_low,
  output logic                 picture_done
);

  import nfb_pkg::*;

  localparam int DEPTH = ROWS * GROUPS;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [8:0]    ROWS9   = 9'(ROWS);
  localparam logic [8:0]    GROUPS9 = 9'(GROUPS);
  localparam logic [8:0]    CLIP9   = 9'(CLIP_WIDTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  function automatic logic [AW-1:0] word_addr(logic [7:0] row, logic [5:0] grp);
    logic [16:0] full;
    full = 17'(row) * 17'(GROUPS) + 17'(grp);
    return full[AW-1:0];
  endfunction

  function automatic logic in_frame(logic [7:0] row, logic [5:0] grp);
    return (9'(row) < ROWS9) && (9'(grp) < GROUPS9);
  endfunction

  // transaction latch
  logic [2:0] req_q;
  logic [7:0] x_q;
  logic [5:0] y_q;
  logic       on_q;
  logic [7:0] pw_q;
  logic [6:0] ph_q;
  logic [7:0] pic_bits;

  // picture state
  logic [7:0] cursor_col;
  logic [6:0] cursor_row;
  logic [5:0] origin_row;
  logic [7:0] clipped_width;
  logic [6:0] clipped_height;
  logic [3:0] bytes_per_column;
  logic [3:0] byte_in_column;
  logic [7:0] columns_drawn;

  // blit pipeline
  logic [3:0]    bit_idx;
  logic          s1_valid;
  logic          s1_ok;
  logic          s1_on;
  logic [AW-1:0] s1_addr;

  logic [AW-1:0] clr_addr;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [WORD_W-1:0] wdata;
  logic [AW-1:0]    raddr;
  logic [WORD_W-1:0] rdata;

  // pixel transaction address
  logic [7:0]    px_row;
  logic [AW-1:0] px_addr;
  logic          px_ok;

  assign px_row  = {2'b00, y_q};
  assign px_addr = word_addr(px_row, x_q[7:2]);
  assign px_ok   = in_frame(px_row, x_q[7:2]);

  // picture byte: rows drawn by this byte
  logic       pic_active;
  logic [6:0] rows_left;
  logic [3:0] blit_count;
  logic       issue;
  logic [7:0] blit_row;
  logic [AW-1:0] blit_addr;
  logic       blit_ok;

  assign pic_active = columns_drawn < clipped_width;
  assign rows_left  = (cursor_row < clipped_height) ? (clipped_height - cursor_row) : 7'd0;

  always_comb begin
    if (!pic_active) begin
      blit_count = 4'd0;
    end else if (rows_left >= 7'(BITS_PER_BYTE)) begin
      blit_count = BITS_PER_BYTE;
    end else begin
      blit_count = rows_left[3:0];
    end
  end

  assign issue     = cmd.blit_step && (bit_idx < blit_count);
  assign blit_row  = 8'(origin_row) + 8'(cursor_row) + 8'(bit_idx);
  assign blit_addr = word_addr(blit_row, cursor_col[7:2]);
  assign blit_ok   = in_frame(blit_row, cursor_col[7:2]);

  assign status.clear_last = (clr_addr == LAST_ADDR);
  assign status.blit_done  = (bit_idx >= blit_count);

  // begin picture clipping
  logic [8:0] x9, wsum, y9, hsum;
  logic [7:0] setup_cw;
  logic [6:0] setup_ch;
  logic [4:0] bpc_raw;
  logic [3:0] setup_bpc;
  logic [7:0] setup_cols;

  assign x9   = {1'b0, x_q};
  assign wsum = x9 + {1'b0, pw_q};
  assign y9   = {3'b000, y_q};
  assign hsum = y9 + {2'b00, ph_q};

  always_comb begin
    if (x9 >= CLIP9) begin
      setup_cw = 8'd0;
    end else if (wsum > CLIP9) begin
      setup_cw = 8'(CLIP9 - x9);
    end else begin
      setup_cw = pw_q;
    end
    if (y9 >= ROWS9) begin
      setup_ch = 7'd0;
    end else if (hsum > ROWS9) begin
      setup_ch = 7'(ROWS9 - y9);
    end else begin
      setup_ch = ph_q;
    end
  end

  assign bpc_raw    = 5'(({1'b0, ph_q} + 8'd7) >> 3);
  assign setup_bpc  = (bpc_raw > 5'(BPC_MAX)) ? BPC_MAX : bpc_raw[3:0];
  assign setup_cols = ((setup_ch == 7'd0) || (setup_bpc == 4'd0)) ? setup_cw : 8'd0;

  // end of picture byte
  logic [4:0] bic_inc;
  logic       col_wrap;
  logic [7:0] adv_cols;

  assign bic_inc  = {1'b0, byte_in_column} + 5'd1;
  assign col_wrap = bic_inc >= {1'b0, bytes_per_column};
  assign adv_cols = (pic_active && col_wrap) ? columns_drawn + 8'd1 : columns_drawn;

  // frame store ports
  assign raddr = issue ? blit_addr : px_addr;

  always_comb begin
    we    = 1'b0;
    waddr = clr_addr;
    wdata = '0;
    if (cmd.clear_step) begin
      we = 1'b1;
    end else if (s1_valid) begin
      we    = s1_ok;
      waddr = s1_addr;
      wdata = nibble_set(rdata, cursor_col[1:0], s1_on);
    end else if (cmd.mem_update) begin
      we    = (req_q == REQ_DRAW) && px_ok;
      waddr = px_addr;
      wdata = nibble_set(rdata, x_q[1:0], on_q);
    end
  end

  nfb_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_frame (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_q    <= req_type;
      x_q      <= pos_x;
      y_q      <= pos_y;
      on_q     <= pixel_on;
      pw_q     <= pic_width;
      ph_q     <= pic_height;
      pic_bits <= pic_data;
    end else if (issue) begin
      pic_bits <= pic_bits << 1;
    end
    if (issue) begin
      s1_addr <= blit_addr;
      s1_ok   <= blit_ok;
      s1_on   <= pic_bits[7];
    end
    if (cmd.respond) begin
      read_value <= ((req_q == REQ_READ) && px_ok) ? nibble_get(rdata, x_q[1:0]) : 4'd0;
      if ((req_q == REQ_FETCH) && px_ok) begin
        word_high <= 8'((rdata & HIGH_MASK) >> 8);
        word_low  <= 8'(rdata & LOW_MASK);
      end else begin
        word_high <= 8'd0;
        word_low  <= 8'd0;
      end
      if (req_q == REQ_BEGIN) begin
        picture_done <= setup_cols >= setup_cw;
      end else if (req_q == REQ_BYTE) begin
        picture_done <= adv_cols >= clipped_width;
      end else begin
        picture_done <= 1'b0;
      end
    end
  end

  // control and picture state
  always_ff @(posedge clk) begin
    if (rst) begin
      done             <= 1'b0;
      clr_addr         <= '0;
      bit_idx          <= 4'd0;
      s1_valid         <= 1'b0;
      cursor_col       <= 8'd0;
      cursor_row       <= 7'd0;
      origin_row       <= 6'd0;
      clipped_width    <= 8'd0;
      clipped_height   <= 7'd0;
      bytes_per_column <= 4'd0;
      byte_in_column   <= 4'd0;
      columns_drawn    <= 8'd0;
    end else begin
      done     <= cmd.respond;
      s1_valid <= issue;
      if (cmd.clear_step) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cmd.accept) begin
        bit_idx <= 4'd0;
      end else if (issue) begin
        bit_idx <= bit_idx + 4'd1;
      end
      if (cmd.pic_setup && (req_q == REQ_BEGIN)) begin
        clipped_width    <= setup_cw;
        clipped_height   <= setup_ch;
        bytes_per_column <= setup_bpc;
        cursor_col       <= x_q;
        origin_row       <= y_q;
        cursor_row       <= 7'd0;
        byte_in_column   <= 4'd0;
        columns_drawn    <= setup_cols;
      end
      if (cmd.pic_advance && pic_active) begin
        if (col_wrap) begin
          byte_in_column <= 4'd0;
          cursor_row     <= 7'd0;
          cursor_col     <= cursor_col + 8'd1;
          columns_drawn  <= columns_drawn + 8'd1;
        end else begin
          byte_in_column <= bic_inc[3:0];
          cursor_row     <= cursor_row + 7'(blit_count);
        end
      end
    end
  end

endmodule

/* rtl/nibble_framebuffer_blitter.sv */
// ----------------------------------------------------------------------------
// nibble_framebuffer_blitter
// 4 bpp framebuffer with pixel access, word fetch and 1 bpp bitmap blit.
// ----------------------------------------------------------------------------
// After reset the block clears its ROWS*GROUPS-word frame store, one word a
// cycle, and holds busy high meanwhile. A transaction is taken when start is
// high and busy low; its result appears on done for exactly one cycle and must
// be captured then. Draw, read, fetch and unknown requests read the word and
// then write it or capture the result, through the single frame store port
// pair; a picture byte's read-modify-writes are pipelined through the store
// one row a cycle. The next transaction may be started in the cycle its
// predecessor's done is shown.
module nibble_framebuffer_blitter #(
  parameter int ROWS       = nfb_pkg::NFB_ROWS,
  parameter int GROUPS     = nfb_pkg::NFB_GROUPS,
  parameter int CLIP_WIDTH = nfb_pkg::NFB_CLIP_WIDTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] req_type,
  input  logic [7:0] pos_x,
  input  logic [5:0] pos_y,
  input  logic       pixel_on,
  input  logic [7:0] pic_width,
  input  logic [6:0] pic_height,
  input  logic [7:0] pic_data,
  output logic       done,
  output logic [3:0] read_value,
  output logic [7:0] word_high,
  output logic [7:0] word_low,
  output logic       picture_done
);

  import nfb_pkg::*;

  nfb_cmd_t    cmd;
  nfb_status_t status;

  nfb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .status   (status),
    .cmd      (cmd),
    .busy     (busy)
  );

  nfb_datapath #(
    .ROWS       (ROWS),
    .GROUPS     (GROUPS),
    .CLIP_WIDTH (CLIP_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .req_type     (req_type),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pixel_on     (pixel_on),
    .pic_width    (pic_width),
    .pic_height   (pic_height),
    .pic_data     (pic_data),
    .done         (done),
    .read_value   (read_value),
    .word_high    (word_high),
    .word_low     (word_low),
    .picture_done (picture_done)
  );

endmodule

/* rtl/nfb_checker.sv */
// ----------------------------------------------------------------------------
// nfb_checker
// Port-level checks on transaction sequencing of the framebuffer blitter.
// ----------------------------------------------------------------------------
module nfb_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // result only once the sequencer is back to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy raised without a transaction");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

endmodule

bind nibble_framebuffer_blitter nfb_checker u_nfb_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

/* dv/tb_nibble_framebuffer_blitter.sv */
// ----------------------------------------------------------------------------
// tb_nibble_framebuffer_blitter
// Self-checking bench for the 4 bpp framebuffer and 1 bpp bitmap blitter.
// ----------------------------------------------------------------------------
// A short directed table covers reset contents, the frame corners, every
// request code, clipping, empty and oversized pictures, and bytes sent after a
// picture is complete. Random traffic follows: mostly well-formed pictures with
// random bitmaps, interleaved with pixel probes, plus random noise requests.
// Each accepted transaction is run through a local frame model; the reply it
// predicts, or a fixed row's table reply, is compared field by field with the
// reply strobed out on done. Sender gaps vary by phase, fully drained between.
// ----------------------------------------------------------------------------
module tb_nibble_framebuffer_blitter;
  timeunit 1ns;
  timeprecision 1ps;

  import nfb_pkg::*;

  localparam int FRAME_WORDS  = NFB_ROWS * NFB_GROUPS;
  localparam int RANDOM_ITEMS = 1850;
  localparam int PHASE_LEN    = 470;
  localparam int STALL_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 24;
  localparam int BURST_CAP    = 160;
  localparam int IDLE_PCT [4] = '{0, 61, 31, 0};

  // request codes the block does not decode
  localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] pos_x;
    logic [5:0] pos_y;
    logic       pixel_on;
    logic [7:0] pic_width;
    logic [6:0] pic_height;
    logic [7:0] pic_data;
  } blit_req_t;

  typedef struct packed {
    logic [3:0] read_value;
    logic [7:0] word_high;
    logic [7:0] word_low;
    logic       picture_done;
  } blit_reply_t;

  typedef struct packed {
    blit_req_t   req;
    logic        fixed;
    blit_reply_t reply;
  } dir_row_t;

  localparam blit_reply_t ZERO_REPLY = '0;
  localparam blit_reply_t PIC_DONE   = '{4'd0, 8'h00, 8'h00, 1'b1};

  localparam int DIR_ROWS = 25;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{'{REQ_READ,  8'd0,   6'd0,  1'b0, 8'd0,   7'd0,   8'h00}, 1'b1, ZERO_REPLY},
    '{'{REQ_FETCH, 8'd252, 6'd63, 1'b0, 8'd0,   7'd0,   8'h00}, 1'b1, ZERO_REPLY},
    '{'{REQ_BYTE,  8'd0,   6'd0,  1'b0, 8'd0,   7'd0,   8'hff}, 1'b1, PIC_DONE},
    '{'{REQ_DRAW,  8'd0,   6'd0,  1'b1, 8'd0,   7'd0,   8'h00}, 1'b1, ZERO_REPLY},
    '{'{REQ_READ,  8'd0,   6'd0,  1'b0, 8'd0,   7'd0,   8'h00}, 1'b1,
      '{4'd15, 8'h00, 8'h00, 1'b0}},
    '{'{REQ_DRAW,  8'd255, 6'd63, 1'b1, 8'd0,   7'd0,   8'h00}, 1'b1, ZERO_REPLY},
    '{'{REQ_FETCH, 8'd252, 6'd63, 1'b0, 8'd0,   7'd0,   8'h00}, 1'b1,
      '{4'd0, 8'h00, 8'h0f, 1'b0}},
    '{'{REQ_DRAW,  8'd3,   6'd0,  1'b1, 8'd0,   7'd0,   8'h00}, 1'b1, ZERO_REPLY},
    '{'{REQ_FETCH, 8'd0,   6'd0,  1'b0, 8'd0,   7'd0,   8'h00}, 1'b1,
      '{4'd0, 8'hf0, 8'h0f, 1'b0}},
    '{'{REQ_DRAW,  8'd0,   6'd0,  1'b0, 8'd0,   7'd0,   8'h00}, 1'b1, ZERO_REPLY},
    '{'{REQ_READ,  8'd0,   6'd0,  1'b0, 8'd0,   7'd0,   8'h00}, 1'b1, ZERO_REPLY},
    '{'{REQ_UNUSED_HI, 8'd255, 6'd63, 1'b1, 8'd255, 7'd127, 8'hff}, 1'b1, ZERO_REPLY},
    '{'{REQ_UNUSED_LO, 8'd0, 6'd0, 1'b0, 8'd0,   7'd0,   8'h00}, 1'b1, ZERO_REPLY},
    '{'{REQ_BEGIN, 8'd128, 6'd0,  1'b0, 8'd8,   7'd8,   8'h00}, 1'b1, PIC_DONE},
    '{'{REQ_BEGIN, 8'd0,   6'd0,  1'b0, 8'd4,   7'd0,   8'h00}, 1'b1, PIC_DONE},
    '{'{REQ_BEGIN, 8'd10,  6'd5,  1'b0, 8'd2,   7'd3,   8'h00}, 1'b1, ZERO_REPLY},
    '{'{REQ_BYTE,  8'd0,   6'd0,  1'b0, 8'd0,   7'd0,   8'ha0}, 1'b0, ZERO_REPLY},
    '{'{REQ_BYTE,  8'd0,   6'd0,  1'b0, 8'd0,   7'd0,   8'hff}, 1'b0, ZERO_REPLY},
    '{'{REQ_BYTE,  8'd0,   6'd0,  1'b0, 8'd0,   7'd0,   8'h55}, 1'b1, PIC_DONE},
    '{'{REQ_FETCH, 8'd8,   6'd5,  1'b0, 8'd0,   7'd0,   8'h00}, 1'b0, ZERO_REPLY},
    '{'{REQ_FETCH, 8'd8,   6'd7,  1'b0, 8'd0,   7'd0,   8'h00}, 1'b0, ZERO_REPLY},
    '{'{REQ_BEGIN, 8'd120, 6'd60, 1'b0, 8'd128, 7'd64,  8'h00}, 1'b0, ZERO_REPLY},
    '{'{REQ_BYTE,  8'd0,   6'd0,  1'b0, 8'd0,   7'd0,   8'hf0}, 1'b0, ZERO_REPLY},
    '{'{REQ_BEGIN, 8'd0,   6'd0,  1'b0, 8'd1,   7'd127, 8'h00}, 1'b0, ZERO_REPLY},
    '{'{REQ_BEGIN, 8'd0,   6'd0,  1'b0, 8'd128, 7'd64,  8'h00}, 1'b1, ZERO_REPLY}
  };

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic [2:0] req_type;
  logic [7:0] pos_x;
  logic [5:0] pos_y;
  logic       pixel_on;
  logic [7:0] pic_width;
  logic [6:0] pic_height;
  logic [7:0] pic_data;
  logic       done;
  logic [3:0] read_value;
  logic [7:0] word_high;
  logic [7:0] word_low;
  logic       picture_done;

  nibble_framebuffer_blitter dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pixel_on     (pixel_on),
    .pic_width    (pic_width),
    .pic_height   (pic_height),
    .pic_data     (pic_data),
    .done         (done),
    .read_value   (read_value),
    .word_high    (word_high),
    .word_low     (word_low),
    .picture_done (picture_done)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // frame model
  logic [15:0] frame_words [FRAME_WORDS];
  int blit_col;
  int blit_row;
  int blit_top;
  int clip_w;
  int clip_h;
  int col_bytes;
  int byte_idx;
  int cols_done;

  blit_reply_t reply_q [$];
  int          mismatches;
  int          sent;
  int          idle_pct;
  int          stall_cycles;

  function automatic void pixel_write(int x, int y, bit on);
    int          grp;
    logic [15:0] mask;
    grp = x >> 2;
    if (y >= NFB_ROWS || grp >= NFB_GROUPS) return;
    mask = NIBBLE_MASK << ((3 - (x & 3)) * 4);
    if (on) frame_words[y * NFB_GROUPS + grp] |= mask;
    else frame_words[y * NFB_GROUPS + grp] &= ~mask;
  endfunction

  function automatic blit_reply_t frame_execute(blit_req_t rq);
    blit_reply_t r;
    int          x;
    int          y;
    int          grp;
    int          bpc;
    logic [15:0] word;
    r = '0;
    x = rq.pos_x;
    y = rq.pos_y;
    grp = x >> 2;
    case (rq.req_type)
      REQ_DRAW: pixel_write(x, y, rq.pixel_on);
      REQ_READ: begin
        if (y < NFB_ROWS && grp < NFB_GROUPS) begin
          word = frame_words[y * NFB_GROUPS + grp];
          r.read_value = 4'((word >> ((3 - (x & 3)) * 4)) & NIBBLE_MASK);
        end
      end
      REQ_BEGIN: begin
        if (x >= NFB_CLIP_WIDTH) clip_w = 0;
        else if (x + rq.pic_width > NFB_CLIP_WIDTH) clip_w = NFB_CLIP_WIDTH - x;
        else clip_w = rq.pic_width;
        if (y >= NFB_ROWS) clip_h = 0;
        else if (y + rq.pic_height > NFB_ROWS) clip_h = NFB_ROWS - y;
        else clip_h = rq.pic_height;
        bpc = (int'(rq.pic_height) + 7) >> 3;
        col_bytes = (bpc > BPC_MAX) ? BPC_MAX : bpc;
        blit_col = x;
        blit_top = y;
        blit_row = 0;
        byte_idx = 0;
        cols_done = 0;
        if (clip_h == 0 || col_bytes == 0) cols_done = clip_w;
        r.picture_done = (cols_done >= clip_w);
      end
      REQ_BYTE: begin
        if (cols_done < clip_w) begin
          for (int b = 0; b < 8 && blit_row < clip_h; b++) begin
            pixel_write(blit_col, blit_top + blit_row, rq.pic_data[7 - b]);
            blit_row++;
          end
          byte_idx++;
          if (byte_idx >= col_bytes) begin
            byte_idx = 0;
            blit_row = 0;
            blit_col = (blit_col + 1) & 255;
            cols_done = (cols_done + 1) & 255;
          end
        end
        r.picture_done = (cols_done >= clip_w);
      end
      REQ_FETCH: begin
        if (y < NFB_ROWS && grp < NFB_GROUPS) begin
          word = frame_words[y * NFB_GROUPS + grp];
          r.word_high = word[15:8];
          r.word_low = word[7:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Called on a falling edge; returns on the falling edge after the transaction is accepted.
  task automatic send_item(blit_req_t rq, bit fixed, blit_reply_t want);
    blit_reply_t got;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    req_type   <= rq.req_type;
    pos_x      <= rq.pos_x;
    pos_y      <= rq.pos_y;
    pixel_on   <= rq.pixel_on;
    pic_width  <= rq.pic_width;
    pic_height <= rq.pic_height;
    pic_data   <= rq.pic_data;
    start      <= 1'b1;
    do @(posedge clk); while (busy);
    got = frame_execute(rq);
    reply_q.push_back(fixed ? want : got);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain_replies();
    start <= 1'b0;
    @(negedge clk);
    while (reply_q.size() != 0) @(negedge clk);
  endtask

  function automatic blit_req_t random_req();
    blit_req_t rq;
    rq.req_type   = 3'($urandom);
    rq.pos_x      = 8'($urandom);
    rq.pos_y      = 6'($urandom);
    rq.pixel_on   = 1'($urandom);
    rq.pic_width  = 8'($urandom);
    rq.pic_height = 7'($urandom);
    rq.pic_data   = 8'($urandom);
    return rq;
  endfunction

  task automatic noise_item();
    blit_req_t rq;
    rq = random_req();
    case ($urandom_range(3))
      0: rq.req_type = REQ_DRAW;
      1: rq.req_type = REQ_READ;
      2: rq.req_type = REQ_FETCH;
      default: ;
    endcase
    send_item(rq, 1'b0, ZERO_REPLY);
  endtask

  // begin picture, its bytes with pixel probes mixed in, then a look at the result
  task automatic picture_burst();
    blit_req_t rq;
    int        left;
    int        ox;
    int        oy;
    rq = random_req();
    rq.req_type = REQ_BEGIN;
    if ($urandom_range(7) != 0) rq.pos_x = 8'($urandom_range(NFB_CLIP_WIDTH - 1));
    if ($urandom_range(9) != 0) rq.pic_width = 8'($urandom_range(1, 6));
    else if ($urandom_range(1) == 0) rq.pic_width = 8'(NFB_CLIP_WIDTH);
    if ($urandom_range(7) != 0) rq.pic_height = 7'($urandom_range(1, 24));
    send_item(rq, 1'b0, ZERO_REPLY);
    ox = blit_col;
    oy = blit_top;
    left = (clip_w - cols_done) * col_bytes - byte_idx;
    if (left > BURST_CAP) left = BURST_CAP;
    if ($urandom_range(9) == 0) left = $urandom_range(left);
    for (int i = 0; i < left; i++) begin
      if ($urandom_range(4) == 0) begin
        rq = random_req();
        rq.req_type = $urandom_range(1) ? REQ_READ : REQ_FETCH;
        rq.pos_x = 8'(blit_col);
        rq.pos_y = 6'(blit_top + $urandom_range(clip_h));
        send_item(rq, 1'b0, ZERO_REPLY);
      end
      rq = random_req();
      rq.req_type = REQ_BYTE;
      send_item(rq, 1'b0, ZERO_REPLY);
    end
    if ($urandom_range(3) == 0) begin
      rq = random_req();
      rq.req_type = REQ_BYTE;
      send_item(rq, 1'b0, ZERO_REPLY);
    end
    repeat (2) begin
      rq = random_req();
      rq.req_type = $urandom_range(1) ? REQ_READ : REQ_FETCH;
      rq.pos_x = 8'(ox + $urandom_range(7));
      rq.pos_y = 6'(oy + $urandom_range(clip_h));
      send_item(rq, 1'b0, ZERO_REPLY);
    end
  endtask

  // reply checker and watchdog
  always @(posedge clk) begin
    blit_reply_t want;
    if (!rst) begin
      if ((start && !busy) || done) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
      if (done) begin
        if (reply_q.size() == 0) begin
          $error("reply with no transaction outstanding");
          mismatches++;
        end else begin
          want = reply_q.pop_front();
          if (read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value, read_value);
            mismatches++;
          end
          if (word_high !== want.word_high) begin
            $error("word_high: expected %0h, got %0h", want.word_high, word_high);
            mismatches++;
          end
          if (word_low !== want.word_low) begin
            $error("word_low: expected %0h, got %0h", want.word_low, word_low);
            mismatches++;
          end
          if (picture_done !== want.picture_done) begin
            $error("picture_done: expected %0d, got %0d", want.picture_done,
                   picture_done);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    int phase;
    int last_phase;
    rst          = 1'b1;
    start        = 1'b0;
    req_type     = REQ_DRAW;
    pos_x        = '0;
    pos_y        = '0;
    pixel_on     = 1'b0;
    pic_width    = '0;
    pic_height   = '0;
    pic_data     = '0;
    mismatches   = 0;
    sent         = 0;
    idle_pct     = 0;
    stall_cycles = 0;
    last_phase   = 0;
    foreach (frame_words[i]) frame_words[i] = '0;
    blit_col  = 0;
    blit_row  = 0;
    blit_top  = 0;
    clip_w    = 0;
    clip_h    = 0;
    col_bytes = 0;
    byte_idx  = 0;
    cols_done = 0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++)
      send_item(DIRECTED[i].req, DIRECTED[i].fixed, DIRECTED[i].reply);

    while (sent < DIR_ROWS + RANDOM_ITEMS) begin
      phase = ((sent - DIR_ROWS) / PHASE_LEN) % 4;
      if (phase != last_phase) begin
        drain_replies();
        idle_pct = IDLE_PCT[phase];
        last_phase = phase;
      end
      if ($urandom_range(99) < 60) picture_burst();
      else noise_item();
    end

    drain_replies();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && reply_q.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* nibble_framebuffer_blitter.f */
rtl/nfb_pkg.sv
rtl/nfb_ram.sv
rtl/nfb_ctrl.sv
rtl/nfb_datapath.sv
rtl/nibble_framebuffer_blitter.sv
rtl/nfb_checker.sv
dv/tb_nibble_framebuffer_blitter.sv
